// ===== sv/sfc_pkg.sv =====
// Shared types, sizes and helper functions of the 3D space-filling-curve key encoder.
// Used by every module of the encoder; depends on nothing else.
`default_nettype none

package sfc_pkg;

    localparam int BITS      = 10;            // quantized bits per axis
    localparam int AXES      = 3;
    localparam int CW        = 32;            // Q16.16 coordinate width
    localparam int DIFW      = CW + 1;        // difference of two coordinates
    localparam int RW        = DIFW + BITS;   // scaled numerator and partial remainder
    localparam int QW        = BITS + 1;      // quotient with the overflow bit on top
    localparam int NCELL     = BITS + 1;      // one divider cell per quotient bit
    localparam int KEY_W     = 30;
    localparam int HIL_W     = 2 * BITS;
    localparam int HIL_SPLIT = BITS / 2;      // levels below this go in the second stage
    localparam int LVL_W     = $clog2(BITS);
    localparam int IDX_W     = 3;

    typedef enum logic [IDX_W-1:0] {
        REG_MODE  = 3'd0,
        REG_MIN_X = 3'd1,
        REG_MIN_Y = 3'd2,
        REG_MIN_Z = 3'd3,
        REG_MAX_X = 3'd4,
        REG_MAX_Y = 3'd5,
        REG_MAX_Z = 3'd6
    } t_reg_idx;

    typedef logic [AXES-1:0][CW-1:0] t_vec;

    typedef struct packed {
        logic [RW-1:0] rem;
        logic [CW-1:0] den;
        logic [QW-1:0] quo;
        logic          neg;
        logic          zero;
    } t_div_lane;

    typedef t_div_lane [AXES-1:0] t_div_row;

    typedef struct packed {
        logic [BITS-1:0]  x;
        logic [BITS-1:0]  y;
        logic [BITS-1:0]  z;
        logic [HIL_W-1:0] d;
    } t_hil;

    // One level of the Hilbert-style key, working from the top bit down.
    function automatic t_hil hil_level(input t_hil st, input logic [LVL_W-1:0] lvl);
        t_hil            r;
        logic            rx;
        logic            ry;
        logic            rz;
        logic [BITS-1:0] t;
        r  = st;
        rx = st.x[lvl];
        ry = st.y[lvl];
        rz = st.z[lvl];
        // (3*rx) xor ry never carries into the next level's digit.
        r.d[{lvl, 1'b0} +: 2] = {rx, rx ^ ry};
        if (!ry) begin
            if (rx) begin
                r.x = ~r.x;
                r.y = ~r.y;
            end
            t   = r.x;
            r.x = r.y;
            r.y = t;
        end
        if (rz) begin
            r.x = ~r.x;
            r.z = ~r.z;
        end
        t   = r.x;
        r.x = r.z;
        r.z = t;
        return r;
    endfunction

    // Bit interleave with the x bit highest in each triple.
    function automatic logic [3*BITS-1:0] morton(input logic [BITS-1:0] x,
                                                 input logic [BITS-1:0] y,
                                                 input logic [BITS-1:0] z);
        logic [3*BITS-1:0] k;
        k = '0;
        for (int i = 0; i < BITS; i++) begin
            k[3*i+2] = x[i];
            k[3*i+1] = y[i];
            k[3*i]   = z[i];
        end
        return k;
    endfunction

endpackage

`default_nettype wire

// ===== sv/sfc_front.sv =====
// Front end of the encoder: offsets, box ranges and the scaled, sign-normalized numerator.
// Two pipeline stages; depends on sfc_pkg.
`default_nettype none

module sfc_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_en,
    input  wire sfc_pkg::t_vec    i_pos,
    input  wire sfc_pkg::t_vec    i_box_lo,
    input  wire sfc_pkg::t_vec    i_box_hi,
    output logic                  o_valid,
    output sfc_pkg::t_div_row     o_row,
    input  wire logic             i_en_dn
);

    logic                                            r_a_valid;
    logic [sfc_pkg::AXES-1:0][sfc_pkg::DIFW-1:0]     r_diff;
    logic [sfc_pkg::AXES-1:0][sfc_pkg::DIFW-1:0]     r_rng;
    logic [sfc_pkg::AXES-1:0][sfc_pkg::DIFW-1:0]     n_diff;
    logic [sfc_pkg::AXES-1:0][sfc_pkg::DIFW-1:0]     n_rng;
    logic                                            r_b_valid;
    sfc_pkg::t_div_row                               r_row;
    sfc_pkg::t_div_row                               n_row;
    logic                                            w_en_b;

    assign w_en_b = !r_b_valid || i_en_dn;
    assign o_en   = !r_a_valid || w_en_b;

    always_comb begin
        for (int a = 0; a < sfc_pkg::AXES; a++) begin
            n_diff[a] = sfc_pkg::DIFW'($signed(i_pos[a]))
                      - sfc_pkg::DIFW'($signed(i_box_lo[a]));
            n_rng[a]  = sfc_pkg::DIFW'($signed(i_box_hi[a]))
                      - sfc_pkg::DIFW'($signed(i_box_lo[a]));
        end
    end

    // A negative range flips both signs so the divider only sees a positive divisor.
    always_comb begin
        logic                       rneg;
        logic [sfc_pkg::DIFW-1:0]   dmag;
        logic [sfc_pkg::RW-1:0]     shl;
        logic [sfc_pkg::RW-1:0]     ext;
        logic [sfc_pkg::RW-1:0]     num;
        for (int a = 0; a < sfc_pkg::AXES; a++) begin
            rneg = r_rng[a][sfc_pkg::DIFW-1];
            dmag = rneg ? (sfc_pkg::DIFW'(0) - r_rng[a]) : r_rng[a];
            shl  = {r_diff[a], sfc_pkg::BITS'(0)};
            ext  = sfc_pkg::RW'($signed(r_diff[a]));
            num  = rneg ? (ext - shl) : (shl - ext);
            n_row[a].neg  = num[sfc_pkg::RW-1];
            n_row[a].rem  = num[sfc_pkg::RW-1] ? '0 : num;
            n_row[a].den  = dmag[sfc_pkg::CW-1:0];
            n_row[a].quo  = '0;
            n_row[a].zero = (r_rng[a] == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (o_en) begin
                r_a_valid <= i_valid;
            end
            if (w_en_b) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en && i_valid) begin
            r_diff <= n_diff;
            r_rng  <= n_rng;
        end
        if (w_en_b && r_a_valid) begin
            r_row <= n_row;
        end
    end

    assign o_valid = r_b_valid;
    assign o_row   = r_row;

endmodule

`default_nettype wire

// ===== sv/sfc_cell.sv =====
// One cell of the restoring divider chain: one quotient bit for each of the three axes.
// Depends on sfc_pkg.
`default_nettype none

module sfc_cell (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_en,
    input  wire sfc_pkg::t_div_row i_row,
    output logic                   o_valid,
    output sfc_pkg::t_div_row      o_row,
    input  wire logic              i_en_dn
);

    logic              r_valid;
    sfc_pkg::t_div_row r_row;
    sfc_pkg::t_div_row n_row;

    assign o_en = !r_valid || i_en_dn;

    // The divisor stays aligned at the top quotient bit and the remainder shifts left.
    // The first cell's bit says the quotient does not fit and the axis saturates.
    always_comb begin
        logic [sfc_pkg::RW-1:0] dsh;
        logic [sfc_pkg::RW-1:0] sub;
        logic                   ge;
        for (int a = 0; a < sfc_pkg::AXES; a++) begin
            dsh = {1'b0, i_row[a].den, sfc_pkg::BITS'(0)};
            ge  = (i_row[a].rem >= dsh);
            sub = ge ? (i_row[a].rem - dsh) : i_row[a].rem;
            n_row[a].rem  = {sub[sfc_pkg::RW-2:0], 1'b0};
            n_row[a].den  = i_row[a].den;
            n_row[a].quo  = {i_row[a].quo[sfc_pkg::QW-2:0], ge};
            n_row[a].neg  = i_row[a].neg;
            n_row[a].zero = i_row[a].zero;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en && i_valid) begin
            r_row <= n_row;
        end
    end

    assign o_valid = r_valid;
    assign o_row   = r_row;

endmodule

`default_nettype wire

// ===== sv/sfc_curve.sv =====
// Back end of the encoder: saturation, the Hilbert-style levels over two stages,
// the Morton interleave and the output register. Depends on sfc_pkg.
`default_nettype none

module sfc_curve (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_en,
    input  wire sfc_pkg::t_div_row i_row,
    input  wire logic              i_mode,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic [sfc_pkg::KEY_W-1:0] o_curve_key,
    output logic                   o_range_flag
);

    logic                                          r_c_valid;
    sfc_pkg::t_hil                                 r_c_hil;
    sfc_pkg::t_hil                                 n_c_hil;
    logic [sfc_pkg::AXES-1:0][sfc_pkg::BITS-1:0]   r_c_q;
    logic [sfc_pkg::AXES-1:0][sfc_pkg::BITS-1:0]   n_c_q;
    logic                                          r_c_flag;
    logic                                          n_c_flag;
    logic                                          r_o_valid;
    logic [sfc_pkg::KEY_W-1:0]                     r_key;
    logic [sfc_pkg::KEY_W-1:0]                     n_key;
    logic                                          r_flag;
    logic                                          w_en_o;

    assign w_en_o = !r_o_valid || !i_stall;
    assign o_en   = !r_c_valid || w_en_o;

    // Below the box or a zero range gives 0; a quotient past the top gives all ones.
    always_comb begin
        logic bad;
        sfc_pkg::t_hil st;
        n_c_flag = 1'b0;
        for (int a = 0; a < sfc_pkg::AXES; a++) begin
            bad = i_row[a].neg || i_row[a].zero;
            if (bad) begin
                n_c_q[a] = '0;
            end else if (i_row[a].quo[sfc_pkg::BITS]) begin
                n_c_q[a] = '1;
            end else begin
                n_c_q[a] = i_row[a].quo[sfc_pkg::BITS-1:0];
            end
            n_c_flag = n_c_flag || bad || i_row[a].quo[sfc_pkg::BITS];
        end
        st.x = n_c_q[0];
        st.y = n_c_q[1];
        st.z = n_c_q[2];
        st.d = '0;
        for (int l = sfc_pkg::BITS - 1; l >= sfc_pkg::HIL_SPLIT; l--) begin
            st = sfc_pkg::hil_level(st, sfc_pkg::LVL_W'(l));
        end
        n_c_hil = st;
    end

    always_comb begin
        sfc_pkg::t_hil st;
        st = r_c_hil;
        for (int l = sfc_pkg::HIL_SPLIT - 1; l >= 0; l--) begin
            st = sfc_pkg::hil_level(st, sfc_pkg::LVL_W'(l));
        end
        if (i_mode) begin
            n_key = sfc_pkg::KEY_W'(st.d);
        end else begin
            n_key = sfc_pkg::KEY_W'(sfc_pkg::morton(r_c_q[0], r_c_q[1], r_c_q[2]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (o_en) begin
                r_c_valid <= i_valid;
            end
            if (w_en_o) begin
                r_o_valid <= r_c_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en && i_valid) begin
            r_c_hil  <= n_c_hil;
            r_c_q    <= n_c_q;
            r_c_flag <= n_c_flag;
        end
        if (w_en_o && r_c_valid) begin
            r_key  <= n_key;
            r_flag <= r_c_flag;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_curve_key  = r_key;
    assign o_range_flag = r_flag;

endmodule

`default_nettype wire

// ===== sv/sfc_key_encoder_3d_core.sv =====
// Top level of the 3D space-filling-curve key encoder: configuration registers and
// the pipeline of front end, divider cell chain and curve back end. Depends on sfc_pkg.
//
//   channel   direction  handshake            payload
//   point     in         i_valid / o_stall    i_pos_x, i_pos_y, i_pos_z
//   key       out        o_valid / i_stall    o_curve_key, o_range_flag
//   config    in         i_cfg_we             i_cfg_idx, i_cfg_data
//
// One item per cycle while i_stall is low; the pipeline has two front-end stages, eleven
// divider cells (one quotient bit each, the first one detecting overflow) and two back-end
// stages, the second of which is the output register.
// Each stage holds its item until the next stage has room, so bubbles close up and new
// items enter while a result waits at the output. Reset is synchronous and active low;
// it empties the pipeline and restores the default box and Morton mode.
`default_nettype none

module sfc_key_encoder_3d_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic [sfc_pkg::CW-1:0]      i_pos_x,
    input  wire logic [sfc_pkg::CW-1:0]      i_pos_y,
    input  wire logic [sfc_pkg::CW-1:0]      i_pos_z,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic [sfc_pkg::KEY_W-1:0]        o_curve_key,
    output logic                             o_range_flag,
    input  wire logic                        i_cfg_we,
    input  wire logic [sfc_pkg::IDX_W-1:0]   i_cfg_idx,
    input  wire logic [sfc_pkg::CW-1:0]      i_cfg_data
);

    logic              r_mode;
    sfc_pkg::t_vec     r_lo;
    sfc_pkg::t_vec     r_hi;
    sfc_pkg::t_vec     w_pos;
    logic              w_front_en;

    logic              w_valid [sfc_pkg::NCELL+1];
    logic              w_en    [sfc_pkg::NCELL+1];
    sfc_pkg::t_div_row w_row   [sfc_pkg::NCELL+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            for (int a = 0; a < sfc_pkg::AXES; a++) begin
                r_lo[a] <= '0;
                r_hi[a] <= sfc_pkg::CW'(65536);
            end
        end else if (i_cfg_we) begin
            case (sfc_pkg::t_reg_idx'(i_cfg_idx))
                sfc_pkg::REG_MODE:  r_mode  <= i_cfg_data[0];
                sfc_pkg::REG_MIN_X: r_lo[0] <= i_cfg_data;
                sfc_pkg::REG_MIN_Y: r_lo[1] <= i_cfg_data;
                sfc_pkg::REG_MIN_Z: r_lo[2] <= i_cfg_data;
                sfc_pkg::REG_MAX_X: r_hi[0] <= i_cfg_data;
                sfc_pkg::REG_MAX_Y: r_hi[1] <= i_cfg_data;
                sfc_pkg::REG_MAX_Z: r_hi[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_pos[0] = i_pos_x;
    assign w_pos[1] = i_pos_y;
    assign w_pos[2] = i_pos_z;
    assign o_stall  = !w_front_en;

    sfc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_en     (w_front_en),
        .i_pos    (w_pos),
        .i_box_lo (r_lo),
        .i_box_hi (r_hi),
        .o_valid  (w_valid[0]),
        .o_row    (w_row[0]),
        .i_en_dn  (w_en[0])
    );

    for (genvar k = 0; k < sfc_pkg::NCELL; k++) begin : g_cell
        sfc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .o_en    (w_en[k]),
            .i_row   (w_row[k]),
            .o_valid (w_valid[k+1]),
            .o_row   (w_row[k+1]),
            .i_en_dn (w_en[k+1])
        );
    end

    sfc_curve u_curve (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_valid[sfc_pkg::NCELL]),
        .o_en         (w_en[sfc_pkg::NCELL]),
        .i_row        (w_row[sfc_pkg::NCELL]),
        .i_mode       (r_mode),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_curve_key  (o_curve_key),
        .o_range_flag (o_range_flag)
    );

endmodule

`default_nettype wire

// ===== sv/sfc_checker.sv =====
// Port-level checks of the key encoder, attached to the top level by the bind below.
// Depends on sfc_pkg and sfc_key_encoder_3d_core.
`default_nettype none

module sfc_checker (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      i_in_valid,
    input wire logic                      i_in_stall,
    input wire logic                      i_out_valid,
    input wire logic                      i_out_stall,
    input wire logic [sfc_pkg::KEY_W-1:0] i_curve_key,
    input wire logic                      i_range_flag
);

    localparam int DEPTH = sfc_pkg::NCELL + 4;
    localparam int CNT_W = $clog2(DEPTH + 2);

    logic [CNT_W-1:0] r_cnt;
    logic             w_in_acc;
    logic             w_out_acc;

    assign w_in_acc  = i_in_valid && !i_in_stall;
    assign w_out_acc = i_out_valid && !i_out_stall;

    // Items inside the encoder, counted at the ports.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (w_in_acc && !w_out_acc) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end else if (w_out_acc && !w_in_acc) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_curve_key)
                                       && $stable(i_range_flag))
        else $error("held result changed or vanished");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_stall |-> i_out_valid && i_out_stall)
        else $error("input stalled without a blocked result");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_cnt != '0)
        else $error("result shown with no item inside");

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(DEPTH))
        else $error("more items inside than pipeline stages");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && !i_in_stall)
        else $error("pipeline not empty after reset");

endmodule

bind sfc_key_encoder_3d_core sfc_checker u_sfc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_valid),
    .i_in_stall   (o_stall),
    .i_out_valid  (o_valid),
    .i_out_stall  (i_stall),
    .i_curve_key  (o_curve_key),
    .i_range_flag (o_range_flag)
);

`default_nettype wire
